FILE: rtl/assert_macros.svh
// Assertion macros for the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/pett_pkg.sv
package pett_pkg;

   typedef enum logic [2:0] {
      KIND_ADD        = 3'd0,
      KIND_REMOVE     = 3'd1,
      KIND_SET_PERIOD = 3'd2,
      KIND_ACTIVATE   = 3'd3,
      KIND_DEACTIVATE = 3'd4,
      KIND_POLL       = 3'd5
   } kind_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] handler;
      logic [2:0]  slot_index;
      logic [31:0] period_ms;
      logic [31:0] now_tick;
   } req_type;

   typedef struct packed {
      logic        error;
      logic [2:0]  result_slot;
      logic        fire;
      logic [15:0] fired_handler;
   } rsp_type;

   // Classified command from the front part.
   typedef enum logic [2:0] {
      OP_ADD, OP_REMOVE, OP_SET_PERIOD, OP_ACTIVATE, OP_DEACTIVATE, OP_POLL, OP_ERROR
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_SCAN, ST_DONE
   } state_type;

endpackage

FILE: rtl/pett_front.sv
module pett_front #(
   parameter int SLOTS = 8,
   parameter int SW = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  pett_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output pett_pkg::op_type  cmd_op,
   output logic [SW-1:0]     cmd_slot,
   output logic [15:0]       cmd_handler,
   output logic [31:0]       cmd_period,
   output logic [31:0]       cmd_now
);
   import pett_pkg::*;

   // Two-entry queue between classifier and execution.
   logic [1:0]    count_ff, count_in;
   logic          wp_ff, wp_in, rp_ff, rp_in;
   op_type        op_ff [2];
   logic [SW-1:0] slot_ff [2];
   logic [15:0]   hnd_ff [2];
   logic [31:0]   per_ff [2];
   logic [31:0]   now_ff [2];
   op_type        op_in;
   logic          push_ok, pop_ok;

   assign req_full = (count_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = cmd_pop && cmd_valid;

   // Classify: range check folds bad slots, and unknown kinds, into an error op.
   always_comb begin
      logic idx_ok;
      idx_ok = ({29'd0, req_data.slot_index} < 32'(SLOTS));
      unique case (req_data.kind)
         KIND_ADD:        op_in = OP_ADD;
         KIND_REMOVE:     op_in = idx_ok ? OP_REMOVE : OP_ERROR;
         KIND_SET_PERIOD: op_in = idx_ok ? OP_SET_PERIOD : OP_ERROR;
         KIND_ACTIVATE:   op_in = idx_ok ? OP_ACTIVATE : OP_ERROR;
         KIND_DEACTIVATE: op_in = idx_ok ? OP_DEACTIVATE : OP_ERROR;
         KIND_POLL:       op_in = OP_POLL;
         default:         op_in = OP_ERROR;
      endcase
      count_in = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
      wp_in    = wp_ff ^ push_ok;
      rp_in    = rp_ff ^ pop_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
      end
      if (push_ok) begin
         op_ff[wp_ff]   <= op_in;
         slot_ff[wp_ff] <= SW'(req_data.slot_index);
         hnd_ff[wp_ff]  <= req_data.handler;
         per_ff[wp_ff]  <= req_data.period_ms;
         now_ff[wp_ff]  <= req_data.now_tick;
      end
   end

   assign cmd_valid   = (count_ff != 2'd0);
   assign cmd_op      = op_ff[rp_ff];
   assign cmd_slot    = slot_ff[rp_ff];
   assign cmd_handler = hnd_ff[rp_ff];
   assign cmd_period  = per_ff[rp_ff];
   assign cmd_now     = now_ff[rp_ff];
endmodule

FILE: rtl/pett_back.sv
module pett_back #(
   parameter int SLOTS = 8,
   parameter int SW = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  pett_pkg::op_type  cmd_op,
   input  logic [SW-1:0]     cmd_slot,
   input  logic [15:0]       cmd_handler,
   input  logic [31:0]       cmd_period,
   input  logic [31:0]       cmd_now,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pett_pkg::rsp_type rsp_data
);
   import pett_pkg::*;

   logic [15:0]   hnd_ff [SLOTS];
   logic [SLOTS-1:0] act_ff;
   logic [31:0]   per_ff [SLOTS];
   logic [31:0]   stamp_ff [SLOTS];
   logic [SW-1:0] ptr_ff, ptr_in;
   state_type     state_ff, state_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic          dup_ff, dup_in, free_ok_ff, free_ok_in;
   logic [SW-1:0] free_ff, free_in;
   rsp_type       rsp_ff, rsp_in;
   logic          full_ff, full_in;
   logic          wr_hnd, wr_act, act_val, wr_per, wr_stamp;
   logic [SW-1:0] wr_idx;
   logic [15:0]   hnd_val;
   logic [31:0]   per_val;
   logic [SW-1:0] nxt_ptr;
   logic [31:0]   elapsed;

   assign nxt_ptr = (ptr_ff == SW'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
   assign elapsed = cmd_now - stamp_ff[nxt_ptr];
   assign rsp_empty = !full_ff;
   assign rsp_data  = rsp_ff;

   // Next state: add scans one slot a cycle, then commits in ST_DONE; other ops go straight to ST_DONE.
   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      dup_in = dup_ff;
      free_ok_in = free_ok_ff;
      free_in = free_ff;
      ptr_in = ptr_ff;
      rsp_in = rsp_ff;
      full_in = full_ff && !rsp_pop;
      cmd_pop = 1'b0;
      wr_hnd = 1'b0; wr_act = 1'b0; act_val = 1'b0; wr_per = 1'b0; wr_stamp = 1'b0;
      wr_idx = cmd_slot; hnd_val = '0; per_val = cmd_period;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !full_in) begin
               rsp_in = '0;
               state_in = ST_DONE;
               unique case (cmd_op)
                  OP_ADD: begin
                     scan_in = '0; dup_in = 1'b0; free_ok_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_REMOVE: begin
                     wr_hnd = 1'b1; wr_act = 1'b1;
                  end
                  OP_SET_PERIOD: wr_per = 1'b1;
                  OP_ACTIVATE: begin
                     if (hnd_ff[cmd_slot] == '0) rsp_in.error = 1'b1;
                     else begin
                        wr_act = 1'b1; act_val = 1'b1; wr_stamp = 1'b1;
                     end
                  end
                  OP_DEACTIVATE: wr_act = 1'b1;
                  OP_POLL: begin
                     ptr_in = nxt_ptr;
                     wr_idx = nxt_ptr;
                     rsp_in.result_slot = 3'(nxt_ptr);
                     if (act_ff[nxt_ptr] && elapsed >= per_ff[nxt_ptr]) begin
                        wr_stamp = 1'b1;
                        rsp_in.fire = 1'b1;
                        rsp_in.fired_handler = hnd_ff[nxt_ptr];
                     end
                  end
                  default: rsp_in.error = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            if (hnd_ff[scan_ff] == cmd_handler) dup_in = 1'b1;
            if (!free_ok_ff && hnd_ff[scan_ff] == '0) begin
               free_ok_in = 1'b1; free_in = scan_ff;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == SW'(SLOTS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            // Commit the add, then hand the result over.
            if (cmd_op == OP_ADD) begin
               if (cmd_handler == '0 || dup_ff || !free_ok_ff) rsp_in.error = 1'b1;
               else begin
                  wr_idx = free_ff; wr_hnd = 1'b1; hnd_val = cmd_handler;
                  wr_act = 1'b1; wr_per = 1'b1;
                  rsp_in.result_slot = 3'(free_ff);
               end
            end
            cmd_pop = 1'b1;
            full_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (wr_stamp) per_val = cmd_period;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         full_ff <= 1'b0;
         ptr_ff <= '0;
         act_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            hnd_ff[i] <= '0; per_ff[i] <= '0; stamp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         full_ff <= full_in;
         ptr_ff <= ptr_in;
         if (wr_hnd) hnd_ff[wr_idx] <= hnd_val;
         if (wr_act) act_ff[wr_idx] <= act_val;
         if (wr_per) per_ff[wr_idx] <= per_val;
         if (wr_stamp) stamp_ff[wr_idx] <= cmd_now;
      end
      scan_ff <= scan_in;
      dup_ff <= dup_in;
      free_ok_ff <= free_ok_in;
      free_ff <= free_in;
      rsp_ff <= rsp_in;
   end
endmodule

FILE: rtl/periodic_event_timer_table_core.sv
// An add is executed from the queue head by scanning every slot in turn (ST_SCAN),
// then committing in ST_DONE; other commands go from ST_IDLE straight to ST_DONE.
// The single execution sequencer takes one command at a time: it takes the next
// only after the last has finished and its result is popped.
// Reset (synchronous, active high) frees all slots and clears the poll pointer.
`include "assert_macros.svh"
module periodic_event_timer_table_core #(
   parameter int SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  pett_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pett_pkg::rsp_type rsp_data
);
   import pett_pkg::*;
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic          cmd_valid, cmd_pop;
   op_type        cmd_op;
   logic [SW-1:0] cmd_slot;
   logic [15:0]   cmd_handler;
   logic [31:0]   cmd_period, cmd_now;

   pett_front #(.SLOTS(SLOTS), .SW(SW)) u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .cmd_valid, .cmd_pop, .cmd_op, .cmd_slot, .cmd_handler, .cmd_period, .cmd_now
   );

   pett_back #(.SLOTS(SLOTS), .SW(SW)) u_back (
      .clock, .reset, .cmd_valid, .cmd_pop, .cmd_op, .cmd_slot, .cmd_handler,
      .cmd_period, .cmd_now, .rsp_empty, .rsp_pop, .rsp_data
   );

   `ASSERT_IMPL(a_pop_valid, clock, reset, cmd_pop, cmd_valid)
   `ASSERT_IMPL(a_fire_handler, clock, reset, !rsp_empty && rsp_data.fire, |rsp_data.fired_handler)
   `ASSERT_NEXT(a_rsp_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty)
endmodule
